### rtl/vrp_pkg.sv
// Shared constants, widths, register codes and helpers for the vertex rotate/project unit.
`timescale 1ns / 1ps

package vrp_pkg;

  // Field widths
  localparam int COORD_BITS = 16;
  localparam int ANGLE_BITS = 16;
  localparam int SCR_W      = 12;
  localparam int OUT_W      = 16;
  localparam int FRAC_BITS  = 12;
  localparam int TRIG_BITS  = 14;
  localparam int TRIG_W     = 16;

  // Configuration port
  localparam int CFG_W = (ANGLE_BITS > SCR_W) ? ANGLE_BITS : SCR_W;
  localparam int IDX_W = 2;

  typedef enum logic [IDX_W-1:0] {
    REG_ANGLE_X   = 2'd0,
    REG_ANGLE_Y   = 2'd1,
    REG_SCREEN_W  = 2'd2,
    REG_SCREEN_H  = 2'd3
  } cfg_reg_t;

  localparam logic [SCR_W-1:0] SCREEN_W_RST = SCR_W'(80);
  localparam logic [SCR_W-1:0] SCREEN_H_RST = SCR_W'(24);

  // Sine polynomial coefficients (Q14)
  localparam int SIN_A = 25736;
  localparam int SIN_B = 10512;
  localparam int SIN_C = 1160;

  // Rotated value width: holds a rotated coordinate and the offset depth
  localparam int RW = ((COORD_BITS > FRAC_BITS + 3) ? COORD_BITS : FRAC_BITS + 3) + 2;
  localparam int ROUND_BIAS   = 1 << (TRIG_BITS - 1);
  localparam int DEPTH_OFFSET = 4 << FRAC_BITS;

  // Projection widths
  localparam int NW    = RW + 14;        // signed numerator
  localparam int MW    = NW - 1;         // numerator magnitude
  localparam int DW    = RW + 1;         // denominator, 2 * depth
  localparam int QBITS = OUT_W - 1;      // quotient bits before saturation
  localparam int CMPW  = DW + QBITS;     // divider compare width
  localparam int DIV_LAT = QBITS + 2;

  // Scale a phase to 16 bits: drop low bits when wider, pad when narrower
  function automatic logic [15:0] phase16(input logic [ANGLE_BITS-1:0] p);
    logic [ANGLE_BITS+15:0] w;
    w = (ANGLE_BITS + 16)'(p) << 16;
    return w[ANGLE_BITS +: 16];
  endfunction

endpackage

### rtl/vrp_sine.sv
// Four-stage pipelined Q1.14 sine of a 16-bit turn phase.
`timescale 1ns / 1ps

module vrp_sine (
  input  logic                              clk,
  input  logic [15:0]                       phase,
  output logic signed [vrp_pkg::TRIG_W-1:0] sine
);
  import vrp_pkg::*;

  logic [14:0] x;
  logic [29:0] sq;
  logic [25:0] pc;
  logic [28:0] pt;
  logic [29:0] pu;
  logic [15:0] s;

  logic [14:0] x1_r, x2_r, x3_r;
  logic [14:0] sq1_r, sq2_r;
  logic [13:0] t2_r;
  logic [14:0] u3_r;
  logic        neg1_r, neg2_r, neg3_r;
  logic signed [TRIG_W-1:0] sine_r;

  // Fold the phase into the first quadrant and square; also form the products of the later stages
  always_comb begin
    x  = phase[14] ? 15'(15'd16384 - {1'b0, phase[13:0]}) : {1'b0, phase[13:0]};
    sq = 30'(x) * 30'(x);
    pc = 26'(sq1_r) * 26'(SIN_C);
    pt = 29'(sq2_r) * 29'(t2_r);
    pu = 30'(x3_r) * 30'(u3_r);
    s  = pu[29:14];
  end

  // Advance the polynomial one term a stage
  always_ff @(posedge clk) begin
    x1_r   <= x;
    sq1_r  <= sq[28:14];
    neg1_r <= phase[15];

    x2_r   <= x1_r;
    sq2_r  <= sq1_r;
    t2_r   <= 14'(SIN_B) - 14'(pc[25:14]);
    neg2_r <= neg1_r;

    x3_r   <= x2_r;
    u3_r   <= 15'(SIN_A) - pt[28:14];
    neg3_r <= neg2_r;

    sine_r <= neg3_r ? -signed'(s) : signed'(s);
  end

  assign sine = sine_r;

endmodule

### rtl/vrp_div.sv
// Pipelined restoring divider, one quotient bit a stage, saturating signed result.
`timescale 1ns / 1ps

module vrp_div (
  input  logic                             clk,
  input  logic [vrp_pkg::MW-1:0]           mag,
  input  logic [vrp_pkg::DW-1:0]           den,
  input  logic                             neg,
  output logic signed [vrp_pkg::OUT_W-1:0] quo
);
  import vrp_pkg::*;

  logic [MW-1:0]    rem_r [QBITS+1];
  logic [DW-1:0]    den_r [QBITS+1];
  logic [QBITS-1:0] q_r   [QBITS+1];
  logic             neg_r [QBITS+1];
  logic             ovf_r [QBITS+1];
  logic signed [OUT_W-1:0] quo_r;
  logic signed [OUT_W-1:0] quo_nxt;

  // Flag quotients that do not fit before iterating
  always_ff @(posedge clk) begin
    rem_r[0] <= mag;
    den_r[0] <= den;
    q_r[0]   <= '0;
    neg_r[0] <= neg;
    ovf_r[0] <= CMPW'(mag) >= (CMPW'(den) << QBITS);
  end

  // One compare and subtract a stage, high bit first
  for (genvar k = 0; k < QBITS; k++) begin : g_stage
    localparam int B = QBITS - 1 - k;
    logic [CMPW-1:0] shd;
    logic [CMPW-1:0] diff;
    logic            ge;

    always_comb begin
      shd  = CMPW'(den_r[k]) << B;
      ge   = CMPW'(rem_r[k]) >= shd;
      diff = CMPW'(rem_r[k]) - shd;
    end

    always_ff @(posedge clk) begin
      rem_r[k+1] <= ge ? MW'(diff) : rem_r[k];
      q_r[k+1]   <= q_r[k] | (ge ? (QBITS'(1) << B) : '0);
      den_r[k+1] <= den_r[k];
      neg_r[k+1] <= neg_r[k];
      ovf_r[k+1] <= ovf_r[k];
    end
  end

  // Apply sign and saturate
  always_comb begin
    priority if (ovf_r[QBITS]) begin
      quo_nxt = neg_r[QBITS] ? {1'b1, {QBITS{1'b0}}} : {1'b0, {QBITS{1'b1}}};
    end else if (neg_r[QBITS]) begin
      quo_nxt = -signed'({1'b0, q_r[QBITS]});
    end else begin
      quo_nxt = signed'({1'b0, q_r[QBITS]});
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
  end

  assign quo = quo_r;

endmodule

### rtl/vertex_rotate_project_unit.sv
// Top level: rotate a vertex about Y then X, offset depth and project to the screen.
`timescale 1ns / 1ps

// Usage:
//   Input beat: drive in_vertex_x/y/z (signed, 12 fraction bits) with start high;
//   the beat is taken at any edge where start is high and busy is low. busy is
//   always low: a new vertex may enter every cycle.
//   Result beat: out_valid is high for one cycle with out_column, out_row and
//   out_behind_viewer. Results appear in order, one per vertex, and the
//   receiver cannot hold them off. Each result is formed through the trig
//   pipelines, the two rotations and the projection products, the
//   bit-per-stage divider and then the output register.
//   Configuration: cfg_we writes cfg_data into register cfg_index (0 angle X,
//   1 angle Y, 2 screen width, 3 screen height) at once; write only while no
//   vertex is in flight.
//   Reset (rst_n low, synchronous) clears the pipeline valid bits and loads
//   angles 0, width 80 and height 24.
module vertex_rotate_project_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [vrp_pkg::COORD_BITS-1:0] in_vertex_x,
  input  logic signed [vrp_pkg::COORD_BITS-1:0] in_vertex_y,
  input  logic signed [vrp_pkg::COORD_BITS-1:0] in_vertex_z,
  input  logic                                 cfg_we,
  input  logic [vrp_pkg::IDX_W-1:0]            cfg_index,
  input  logic [vrp_pkg::CFG_W-1:0]            cfg_data,
  output logic                                 out_valid,
  output logic signed [vrp_pkg::OUT_W-1:0]     out_column,
  output logic signed [vrp_pkg::OUT_W-1:0]     out_row,
  output logic                                 out_behind_viewer
);
  import vrp_pkg::*;

  localparam int VDLY     = 4;
  localparam int PIPE_LEN = VDLY + 6 + DIV_LAT;
  localparam int PW1  = COORD_BITS + TRIG_W;
  localparam int SW1  = PW1 + 1;
  localparam int PW2  = RW + TRIG_W;
  localparam int SW2  = PW2 + 1;
  localparam int VW   = RW + SCR_W + 1;
  localparam int TMW  = DW + SCR_W - 1;

  logic accept;

  // Configuration registers
  logic [ANGLE_BITS-1:0] ang_x_r, ang_y_r;
  logic [SCR_W-1:0]      scr_w_r, scr_h_r;

  // Trig
  logic [15:0] ph_x, ph_y;
  logic signed [TRIG_W-1:0] sin_x, cos_x, sin_y, cos_y;

  // Valid line
  logic [PIPE_LEN-1:0] vld_r;

  // Vertex delay to meet the trig outputs
  logic signed [COORD_BITS-1:0] vx_d_r [VDLY];
  logic signed [COORD_BITS-1:0] vy_d_r [VDLY];
  logic signed [COORD_BITS-1:0] vz_d_r [VDLY];

  // First rotation
  logic signed [PW1-1:0] p_zc_r, p_xs_r, p_zs_r, p_xc_r;
  logic signed [COORD_BITS-1:0] vy_m1_r, vy_m2_r;
  logic signed [TRIG_W-1:0] sx_m1_r, cx_m1_r, sx_m2_r, cx_m2_r;
  logic signed [SW1-1:0] sum_z, sum_x;
  logic signed [RW-1:0]  rz_m2_r, rx_m2_r, rx_m3_r, rx_m4_r;

  // Second rotation
  logic signed [PW2-1:0] q_yc_r, q_zs_r, q_ys_r, q_zc_r;
  logic signed [SW2-1:0] sum_y2, sum_z2;
  logic signed [RW-1:0]  rz2, ry_m4_r, depth_m4_r;

  // Projection
  logic signed [SCR_W:0]  w_s, h_s;
  logic [DW-1:0]          den_m4;
  logic signed [VW-1:0]   vw_m5_r, vh_m5_r;
  logic [TMW-1:0]         tw_m5_r, th_m5_r;
  logic [DW-1:0]          den_m5_r, den_m6_r;
  logic                   beh_m5_r, beh_m6_r;
  logic signed [NW-1:0]   num_c, num_r;
  logic [MW-1:0]          mag_c_r, mag_r_r;
  logic                   neg_c_r, neg_r_r;
  logic [DIV_LAT-1:0]     beh_d_r;
  logic signed [OUT_W-1:0] quo_c, quo_r;

  // Output register
  logic                    out_valid_r, out_behind_r;
  logic signed [OUT_W-1:0] out_column_r, out_row_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_x_r <= '0;
      ang_y_r <= '0;
      scr_w_r <= SCREEN_W_RST;
      scr_h_r <= SCREEN_H_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ANGLE_X:  ang_x_r <= cfg_data[ANGLE_BITS-1:0];
        REG_ANGLE_Y:  ang_y_r <= cfg_data[ANGLE_BITS-1:0];
        REG_SCREEN_W: scr_w_r <= cfg_data[SCR_W-1:0];
        REG_SCREEN_H: scr_h_r <= cfg_data[SCR_W-1:0];
      endcase
    end
  end

  // Sine and cosine of both angles; cosine is a quarter turn ahead
  assign ph_x = phase16(ang_x_r);
  assign ph_y = phase16(ang_y_r);

  vrp_sine u_sin_x (.clk(clk), .phase(ph_x),            .sine(sin_x));
  vrp_sine u_cos_x (.clk(clk), .phase(ph_x + 16'h4000), .sine(cos_x));
  vrp_sine u_sin_y (.clk(clk), .phase(ph_y),            .sine(sin_y));
  vrp_sine u_cos_y (.clk(clk), .phase(ph_y + 16'h4000), .sine(cos_y));

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[PIPE_LEN-2:0], accept};
    end
  end

  // Hold the vertex until its trig values arrive
  always_ff @(posedge clk) begin
    vx_d_r[0] <= in_vertex_x;
    vy_d_r[0] <= in_vertex_y;
    vz_d_r[0] <= in_vertex_z;
    for (int i = 1; i < VDLY; i++) begin
      vx_d_r[i] <= vx_d_r[i-1];
      vy_d_r[i] <= vy_d_r[i-1];
      vz_d_r[i] <= vz_d_r[i-1];
    end
  end

  // Rotate about Y: products, then round back to 12 fraction bits
  always_comb begin
    sum_z = (SW1'(p_zc_r) - SW1'(p_xs_r) + SW1'(ROUND_BIAS)) >>> TRIG_BITS;
    sum_x = (SW1'(p_zs_r) + SW1'(p_xc_r) + SW1'(ROUND_BIAS)) >>> TRIG_BITS;
  end

  always_ff @(posedge clk) begin
    p_zc_r  <= PW1'(vz_d_r[VDLY-1]) * PW1'(cos_y);
    p_xs_r  <= PW1'(vx_d_r[VDLY-1]) * PW1'(sin_y);
    p_zs_r  <= PW1'(vz_d_r[VDLY-1]) * PW1'(sin_y);
    p_xc_r  <= PW1'(vx_d_r[VDLY-1]) * PW1'(cos_y);
    vy_m1_r <= vy_d_r[VDLY-1];
    sx_m1_r <= sin_x;
    cx_m1_r <= cos_x;

    rz_m2_r <= RW'(sum_z);
    rx_m2_r <= RW'(sum_x);
    vy_m2_r <= vy_m1_r;
    sx_m2_r <= sx_m1_r;
    cx_m2_r <= cx_m1_r;
  end

  // Rotate about X and add the depth offset
  always_comb begin
    sum_y2 = (SW2'(q_yc_r) - SW2'(q_zs_r) + SW2'(ROUND_BIAS)) >>> TRIG_BITS;
    sum_z2 = (SW2'(q_ys_r) + SW2'(q_zc_r) + SW2'(ROUND_BIAS)) >>> TRIG_BITS;
    rz2    = RW'(sum_z2);
  end

  always_ff @(posedge clk) begin
    q_yc_r  <= PW2'(vy_m2_r) * PW2'(cx_m2_r);
    q_zs_r  <= PW2'(rz_m2_r) * PW2'(sx_m2_r);
    q_ys_r  <= PW2'(vy_m2_r) * PW2'(sx_m2_r);
    q_zc_r  <= PW2'(rz_m2_r) * PW2'(cx_m2_r);
    rx_m3_r <= rx_m2_r;

    ry_m4_r    <= RW'(sum_y2);
    depth_m4_r <= rz2 + RW'(DEPTH_OFFSET);
    rx_m4_r    <= rx_m3_r;
  end

  // Projection numerators: v * size + (size / 2) * 2 * depth
  always_comb begin
    w_s    = signed'({1'b0, scr_w_r});
    h_s    = signed'({1'b0, scr_h_r});
    den_m4 = {depth_m4_r[RW-1:0], 1'b0};
    num_c  = NW'(vw_m5_r) + NW'(signed'({1'b0, tw_m5_r}));
    num_r  = NW'(vh_m5_r) + NW'(signed'({1'b0, th_m5_r}));
  end

  always_ff @(posedge clk) begin
    vw_m5_r  <= VW'(rx_m4_r) * VW'(w_s);
    vh_m5_r  <= VW'(ry_m4_r) * VW'(h_s);
    tw_m5_r  <= TMW'(scr_w_r[SCR_W-1:1]) * TMW'(den_m4);
    th_m5_r  <= TMW'(scr_h_r[SCR_W-1:1]) * TMW'(den_m4);
    den_m5_r <= den_m4;
    beh_m5_r <= depth_m4_r[RW-1] || (depth_m4_r == '0);

    neg_c_r  <= num_c[NW-1];
    neg_r_r  <= num_r[NW-1];
    mag_c_r  <= num_c[NW-1] ? MW'(-num_c) : MW'(num_c);
    mag_r_r  <= num_r[NW-1] ? MW'(-num_r) : MW'(num_r);
    den_m6_r <= den_m5_r;
    beh_m6_r <= beh_m5_r;

    beh_d_r  <= {beh_d_r[DIV_LAT-2:0], beh_m6_r};
  end

  // Divide both axes by twice the depth
  vrp_div u_div_c (
    .clk (clk),
    .mag (mag_c_r),
    .den (den_m6_r),
    .neg (neg_c_r),
    .quo (quo_c)
  );

  vrp_div u_div_r (
    .clk (clk),
    .mag (mag_r_r),
    .den (den_m6_r),
    .neg (neg_r_r),
    .quo (quo_r)
  );

  // Drive the result beat; zero the point when it lies behind the viewer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      out_behind_r <= 1'b0;
    end else begin
      out_valid_r  <= vld_r[PIPE_LEN-1];
      out_behind_r <= vld_r[PIPE_LEN-1] && beh_d_r[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    out_column_r <= beh_d_r[DIV_LAT-1] ? '0 : quo_c;
    out_row_r    <= beh_d_r[DIV_LAT-1] ? '0 : quo_r;
  end

  assign out_valid         = out_valid_r;
  assign out_behind_viewer = out_behind_r;
  assign out_column        = out_column_r;
  assign out_row           = out_row_r;

  // Every result beat traces back to an accepted vertex
  a_out_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, PIPE_LEN + 1))
    else $error("result beat without a matching input beat");

  // A point behind the viewer reports zero coordinates
  a_behind_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_behind_viewer) |-> (out_column == '0 && out_row == '0))
    else $error("behind-viewer result with nonzero coordinates");

  // The flag never shows outside a result beat
  a_behind_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_behind_viewer |-> out_valid)
    else $error("behind-viewer flag outside a result beat");

endmodule
